### design/bole_pkg.sv
// bole_pkg: shared widths, codes and cell command types for the bounded
// ordered list engine. No dependencies; used by every design file.
`timescale 1ns / 1ps

package bole_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int CAP_W    = 9;

    localparam int DEFAULT_DEPTH = 256;

    localparam logic [CAP_W-1:0]   CAP_RESET = 9'd256;
    localparam logic [VALUE_W-1:0] MIN_WORD  = 32'h8000_0000;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_INS_FIRST = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_LAST  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEARCH    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_UPDATE    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd7;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // per-cell operation
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_UPDATE = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] data;
    } cell_cmd_t;

    typedef struct packed {
        logic               search;
        logic [VALUE_W-1:0] key;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
    } lookup_t;

endpackage

### design/bole_cell.sv
// bole_cell: one list entry. Shifts from its neighbors on insert/delete,
// takes new data on update, and flags a lookup hit. Depends on bole_pkg.
`timescale 1ns / 1ps

module bole_cell #(
    parameter int INDEX = 0,
    parameter int CMPW  = 9
) (
    input  logic                           clk,
    input  bole_pkg::cell_cmd_t            cmd,
    input  bole_pkg::lookup_t              lookup,
    input  logic [bole_pkg::VALUE_W-1:0]   left_value,
    input  logic [bole_pkg::VALUE_W-1:0]   right_value,
    output logic [bole_pkg::VALUE_W-1:0]   value,
    output logic                           hit
);

    localparam logic [CMPW-1:0] IDX  = CMPW'(INDEX);
    localparam logic [CMPW-1:0] IDX1 = CMPW'(INDEX + 1);

    logic [bole_pkg::VALUE_W-1:0] value_reg;
    logic [bole_pkg::VALUE_W-1:0] value_next;
    logic [CMPW-1:0]              pos_x;
    logic [CMPW-1:0]              cnt_x;
    logic [CMPW-1:0]              lpos_x;
    logic [CMPW-1:0]              lcnt_x;

    assign pos_x  = CMPW'(cmd.pos);
    assign cnt_x  = CMPW'(cmd.count);
    assign lpos_x = CMPW'(lookup.pos);
    assign lcnt_x = CMPW'(lookup.count);

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.kind)
            bole_pkg::CELL_INSERT:
            begin
                if (IDX == pos_x)
                begin
                    value_next = cmd.data;
                end
                else if (IDX > pos_x && IDX <= cnt_x)
                begin
                    value_next = left_value;
                end
            end
            bole_pkg::CELL_DELETE:
            begin
                // the vacated last slot reads back as zero
                if (IDX1 == cnt_x)
                begin
                    value_next = '0;
                end
                else if (IDX >= pos_x && IDX1 < cnt_x)
                begin
                    value_next = right_value;
                end
            end
            bole_pkg::CELL_UPDATE:
            begin
                if (IDX == pos_x)
                begin
                    value_next = cmd.data;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign hit   = lookup.search ? (value_reg == lookup.key && IDX < lcnt_x)
                                 : (IDX == lpos_x);

endmodule

### design/bole_tree.sv
// bole_tree: registered binary find-first tree over the cell hit flags;
// returns the lowest hitting index and its value. Depends on bole_pkg.
`timescale 1ns / 1ps

module bole_tree #(
    parameter int DEPTH = bole_pkg::DEFAULT_DEPTH,
    parameter int IW    = $clog2(bole_pkg::DEFAULT_DEPTH)
) (
    input  logic                           clk,
    input  logic [DEPTH-1:0]               leaf_hit,
    input  logic [bole_pkg::VALUE_W-1:0]   leaf_value [DEPTH],
    output logic                           root_hit,
    output logic [IW-1:0]                  root_index,
    output logic [bole_pkg::VALUE_W-1:0]   root_value
);

    localparam int NP = 1 << IW;

    logic                         node_hit [2*NP];
    logic [IW-1:0]                node_idx [2*NP];
    logic [bole_pkg::VALUE_W-1:0] node_val [2*NP];

    for (genvar k = 0; k < NP; k++)
    begin : g_leaf
        if (k < DEPTH)
        begin : g_real
            assign node_hit[NP+k] = leaf_hit[k];
            assign node_val[NP+k] = leaf_value[k];
        end
        else
        begin : g_pad
            assign node_hit[NP+k] = 1'b0;
            assign node_val[NP+k] = '0;
        end
        assign node_idx[NP+k] = IW'(k);
    end

    // lower index wins: take the left child whenever it hits
    for (genvar k = 1; k < NP; k++)
    begin : g_node
        always_ff @(posedge clk)
        begin
            node_hit[k] <= node_hit[2*k] || node_hit[2*k+1];
            node_idx[k] <= node_hit[2*k] ? node_idx[2*k] : node_idx[2*k+1];
            node_val[k] <= node_hit[2*k] ? node_val[2*k] : node_val[2*k+1];
        end
    end

    assign node_hit[0] = 1'b0;
    assign node_idx[0] = '0;
    assign node_val[0] = '0;

    assign root_hit   = node_hit[1] || node_hit[0];
    assign root_index = node_idx[1];
    assign root_value = node_val[1];

endmodule

### design/bounded_ordered_list_engine_core.sv
// bounded_ordered_list_engine_core: top level of the ordered list engine,
// a row of bole_cell entries plus a bole_tree lookup. Depends on bole_pkg.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ------------------------------
//  request   in         in_valid / in_stall       action, position, item_value
//  result    out        out_valid / out_stall     status, found_index,
//                                                 read_value, entry_count,
//                                                 is_full, is_empty
//  config    in         cfg_valid / cfg_ready     cfg_data (capacity_limit)
//
//  Insert, delete, update, clear and every rejected request are answered
//  directly: the cells shift in parallel and the result register loads at once.
//  A search or a successful read runs the registered find-first tree, with a
//  register at each tree level, and keeps the engine busy until its result loads.
//  Reset clears the count, the busy state and the result valid, and sets
//  the capacity to 256; entry cells are not reset.
//  A stalled result holds and blocks new requests until it is taken.

module bounded_ordered_list_engine_core #(
    parameter int DEPTH = bole_pkg::DEFAULT_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [bole_pkg::ACTION_W-1:0]          action,
    input  logic [bole_pkg::POS_W-1:0]             position,
    input  logic signed [bole_pkg::VALUE_W-1:0]    item_value,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [bole_pkg::STATUS_W-1:0]          status,
    output logic [bole_pkg::FOUND_W-1:0]           found_index,
    output logic signed [bole_pkg::VALUE_W-1:0]    read_value,
    output logic [bole_pkg::COUNT_W-1:0]           entry_count,
    output logic                                   is_full,
    output logic                                   is_empty,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bole_pkg::CAP_W-1:0]             cfg_data
);

    localparam int IW     = $clog2(DEPTH);
    localparam int CMPW   = (IW + 1 > bole_pkg::POS_W) ? IW + 1 : bole_pkg::POS_W;
    localparam int WAIT_W = $clog2(IW + 1);

    localparam logic [CMPW-1:0]   DEPTH_X   = CMPW'(DEPTH);
    localparam logic [WAIT_W-1:0] WAIT_LOAD = WAIT_W'(IW);

    // control state
    logic [bole_pkg::COUNT_W-1:0] count_reg;
    logic [bole_pkg::COUNT_W-1:0] count_next;
    logic [bole_pkg::CAP_W-1:0]   cap_reg;
    logic                         busy_reg;
    logic                         busy_next;
    logic [WAIT_W-1:0]            wait_reg;
    logic [WAIT_W-1:0]            wait_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    // payload state
    bole_pkg::lookup_t            lookup_reg;
    logic [bole_pkg::STATUS_W-1:0] status_reg;
    logic [bole_pkg::FOUND_W-1:0]  found_reg;
    logic [bole_pkg::VALUE_W-1:0]  read_reg;
    logic [bole_pkg::COUNT_W-1:0]  out_count_reg;
    logic                          full_reg;
    logic                          empty_reg;

    // request decode
    logic                          in_accept;
    logic                          done;
    logic [CMPW-1:0]               eff_cap;
    logic                          list_full;
    logic                          new_full;
    logic [bole_pkg::POS_W-1:0]    ins_pos;
    logic [bole_pkg::STATUS_W-1:0] dec_status;
    logic [bole_pkg::COUNT_W-1:0]  dec_count;
    logic [bole_pkg::VALUE_W-1:0]  dec_read;
    logic [1:0]                    dec_kind;
    logic [bole_pkg::POS_W-1:0]    dec_pos;
    logic                          dec_lookup;
    bole_pkg::cell_cmd_t           cell_cmd;

    // cell row and tree
    logic [bole_pkg::VALUE_W-1:0]  cell_value [DEPTH];
    logic [DEPTH-1:0]              cell_hit;
    logic                          root_hit;
    logic [IW-1:0]                 root_index;
    logic [bole_pkg::VALUE_W-1:0]  root_value;

    // hold off new requests while a lookup runs or a result is stuck
    assign in_stall  = busy_reg || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign done      = busy_reg && (wait_reg == '0);
    assign cfg_ready = 1'b1;

    // capacity above DEPTH acts as DEPTH
    assign eff_cap   = (CMPW'(cap_reg) > DEPTH_X) ? DEPTH_X : CMPW'(cap_reg);
    assign list_full = CMPW'(count_reg) >= eff_cap;
    assign new_full  = CMPW'(dec_count) >= eff_cap;

    assign ins_pos = (action == bole_pkg::ACT_INS_FIRST) ? '0 :
                     (action == bole_pkg::ACT_INS_LAST)  ? count_reg : position;

    always_comb
    begin
        dec_status = bole_pkg::ST_OK;
        dec_count  = count_reg;
        dec_read   = '0;
        dec_kind   = bole_pkg::CELL_HOLD;
        dec_pos    = position;
        dec_lookup = 1'b0;
        unique case (action) inside
            bole_pkg::ACT_INS_FIRST, bole_pkg::ACT_INS_LAST, bole_pkg::ACT_INS_AT:
            begin
                // full check wins over the position check
                if (list_full)
                begin
                    dec_status = bole_pkg::ST_FULL;
                end
                else if (ins_pos > count_reg)
                begin
                    dec_status = bole_pkg::ST_BADPOS;
                end
                else
                begin
                    dec_kind  = bole_pkg::CELL_INSERT;
                    dec_pos   = ins_pos;
                    dec_count = count_reg + 1'b1;
                end
            end
            bole_pkg::ACT_DELETE:
            begin
                if (count_reg == '0)
                begin
                    dec_status = bole_pkg::ST_EMPTY;
                end
                else if (position >= count_reg)
                begin
                    dec_status = bole_pkg::ST_BADPOS;
                end
                else
                begin
                    dec_kind  = bole_pkg::CELL_DELETE;
                    dec_count = count_reg - 1'b1;
                end
            end
            bole_pkg::ACT_SEARCH:
            begin
                if (count_reg == '0)
                begin
                    dec_status = bole_pkg::ST_EMPTY;
                end
                else
                begin
                    dec_lookup = 1'b1;
                end
            end
            bole_pkg::ACT_UPDATE:
            begin
                if (count_reg == '0)
                begin
                    dec_status = bole_pkg::ST_EMPTY;
                end
                else if (position >= count_reg)
                begin
                    dec_status = bole_pkg::ST_BADPOS;
                end
                else
                begin
                    dec_kind = bole_pkg::CELL_UPDATE;
                end
            end
            bole_pkg::ACT_READ:
            begin
                if (count_reg == '0)
                begin
                    dec_status = bole_pkg::ST_EMPTY;
                    dec_read   = bole_pkg::MIN_WORD;
                end
                else if (position >= count_reg)
                begin
                    dec_status = bole_pkg::ST_BADPOS;
                    dec_read   = bole_pkg::MIN_WORD;
                end
                else
                begin
                    dec_lookup = 1'b1;
                end
            end
            bole_pkg::ACT_CLEAR:
            begin
                dec_count = '0;
            end
            default:
            begin
                dec_count = count_reg;
            end
        endcase
    end

    // broadcast the cell command only on the accepting edge
    always_comb
    begin
        cell_cmd.kind  = in_accept ? dec_kind : bole_pkg::CELL_HOLD;
        cell_cmd.pos   = dec_pos;
        cell_cmd.count = count_reg;
        cell_cmd.data  = item_value;
    end

    always_comb
    begin
        count_next     = count_reg;
        busy_next      = busy_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (in_accept)
        begin
            count_next = dec_count;
            if (dec_lookup)
            begin
                busy_next = 1'b1;
                wait_next = WAIT_LOAD;
            end
            else
            begin
                out_valid_next = 1'b1;
            end
        end
        else if (done)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (busy_reg)
        begin
            wait_next = wait_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= bole_pkg::CAP_RESET;
            busy_reg      <= 1'b0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // latch the lookup key and load the result register
    always_ff @(posedge clk)
    begin
        if (in_accept && dec_lookup)
        begin
            lookup_reg.search <= (action == bole_pkg::ACT_SEARCH);
            lookup_reg.key    <= item_value;
            lookup_reg.pos    <= position;
            lookup_reg.count  <= count_reg;
        end
        if (in_accept && !dec_lookup)
        begin
            status_reg    <= dec_status;
            found_reg     <= '0;
            read_reg      <= dec_read;
            out_count_reg <= dec_count;
            full_reg      <= new_full;
            empty_reg     <= (dec_count == '0);
        end
        else if (done)
        begin
            if (lookup_reg.search)
            begin
                status_reg <= root_hit ? bole_pkg::ST_OK : bole_pkg::ST_NOTFOUND;
                found_reg  <= root_hit ? bole_pkg::FOUND_W'(root_index) : '0;
                read_reg   <= '0;
            end
            else
            begin
                status_reg <= bole_pkg::ST_OK;
                found_reg  <= '0;
                read_reg   <= root_value;
            end
            out_count_reg <= count_reg;
            full_reg      <= list_full;
            empty_reg     <= (count_reg == '0);
        end
    end

    // row of entry cells, each fed by both neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [bole_pkg::VALUE_W-1:0] left_v;
        logic [bole_pkg::VALUE_W-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_left
            assign left_v = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_right
            assign right_v = cell_value[i+1];
        end

        bole_cell #(
            .INDEX (i),
            .CMPW  (CMPW)
        ) u_cell (
            .clk         (clk),
            .cmd         (cell_cmd),
            .lookup      (lookup_reg),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[i]),
            .hit         (cell_hit[i])
        );
    end

    bole_tree #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_tree (
        .clk        (clk),
        .leaf_hit   (cell_hit),
        .leaf_value (cell_value),
        .root_hit   (root_hit),
        .root_index (root_index),
        .root_value (root_value)
    );

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign read_value  = read_reg;
    assign entry_count = out_count_reg;
    assign is_full     = full_reg;
    assign is_empty    = empty_reg;

`ifndef SYNTHESIS
    // every accepted request either loads a result or starts a lookup
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (out_valid_reg || busy_reg))
        else $error("accepted request produced neither result nor lookup");

    // a finished lookup frees the engine and presents its result
    a_lookup_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy_reg && out_valid_reg))
        else $error("lookup did not complete into the result register");

    // a read only enters the tree with an in-range position, so it must hit
    a_read_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !lookup_reg.search) |-> root_hit)
        else $error("read lookup found no entry");

    // the count never passes the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= DEPTH_X)
        else $error("entry count exceeds cell row");
`endif

endmodule

### verif/bounded_ordered_list_engine_core_test.sv
// Self-checking testbench for bounded_ordered_list_engine_core: directed table, then random
// request phases across several capacity settings, checked against a built-in list predictor.
// Depends on bole_pkg and the engine RTL only.
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core_test;

    localparam int LIST_DEPTH    = bole_pkg::DEFAULT_DEPTH;
    localparam int SETTLE_CYCLES = 12;    // long enough for a lookup at 256 entries
    localparam int QUIET_LIMIT   = 2000;
    localparam int DIRECTED_N    = 25;

    typedef struct packed {
        logic [bole_pkg::STATUS_W-1:0] status;
        logic [bole_pkg::FOUND_W-1:0]  found;
        logic [bole_pkg::VALUE_W-1:0]  value;
        logic [bole_pkg::COUNT_W-1:0]  count;
        logic                          full;
        logic                          empty;
    } list_result_t;

    typedef struct packed {
        logic                          typed;
        logic [bole_pkg::ACTION_W-1:0] act;
        logic [bole_pkg::POS_W-1:0]    pos;
        logic [bole_pkg::VALUE_W-1:0]  val;
        list_result_t                  want;
    } directed_row_t;

    typedef enum int {MIX_FILL, MIX_KEEP, MIX_ANY} op_mix_t;

    localparam logic [bole_pkg::VALUE_W-1:0] MAX_WORD = 32'h7FFF_FFFF;
    localparam logic [bole_pkg::VALUE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // Expected results are typed in only where the list contents make them obvious;
    // the remaining rows fall back to the predictor.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        // empty list after reset
        '{1'b1, bole_pkg::ACT_READ, 9'd0, 32'd0,
          '{bole_pkg::ST_EMPTY, 8'd0, bole_pkg::MIN_WORD, 9'd0, 1'b0, 1'b1}},
        '{1'b1, bole_pkg::ACT_SEARCH, 9'd0, 32'd0,
          '{bole_pkg::ST_EMPTY, 8'd0, 32'd0, 9'd0, 1'b0, 1'b1}},
        '{1'b1, bole_pkg::ACT_DELETE, 9'd0, 32'd0,
          '{bole_pkg::ST_EMPTY, 8'd0, 32'd0, 9'd0, 1'b0, 1'b1}},
        '{1'b1, bole_pkg::ACT_UPDATE, 9'd0, 32'd3,
          '{bole_pkg::ST_EMPTY, 8'd0, 32'd0, 9'd0, 1'b0, 1'b1}},
        '{1'b1, bole_pkg::ACT_INS_AT, 9'd1, 32'd5,
          '{bole_pkg::ST_BADPOS, 8'd0, 32'd0, 9'd0, 1'b0, 1'b1}},
        // build [MAX, -1, MIN] with the three insert flavors
        '{1'b1, bole_pkg::ACT_INS_FIRST, 9'd0, MAX_WORD,
          '{bole_pkg::ST_OK, 8'd0, 32'd0, 9'd1, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_INS_LAST, 9'd511, bole_pkg::MIN_WORD,
          '{bole_pkg::ST_OK, 8'd0, 32'd0, 9'd2, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_INS_AT, 9'd1, ALL_ONES,
          '{bole_pkg::ST_OK, 8'd0, 32'd0, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_READ, 9'd1, 32'd0,
          '{bole_pkg::ST_OK, 8'd0, ALL_ONES, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_SEARCH, 9'd0, bole_pkg::MIN_WORD,
          '{bole_pkg::ST_OK, 8'd2, 32'd0, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_SEARCH, 9'd0, 32'd12345,
          '{bole_pkg::ST_NOTFOUND, 8'd0, 32'd0, 9'd3, 1'b0, 1'b0}},
        // positions at and past the count, and an in-range update
        '{1'b1, bole_pkg::ACT_READ, 9'd3, 32'd0,
          '{bole_pkg::ST_BADPOS, 8'd0, bole_pkg::MIN_WORD, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_READ, 9'd511, 32'd0,
          '{bole_pkg::ST_BADPOS, 8'd0, bole_pkg::MIN_WORD, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_UPDATE, 9'd0, 32'd0,
          '{bole_pkg::ST_OK, 8'd0, 32'd0, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_UPDATE, 9'd3, 32'd9,
          '{bole_pkg::ST_BADPOS, 8'd0, 32'd0, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_DELETE, 9'd3, 32'd0,
          '{bole_pkg::ST_BADPOS, 8'd0, 32'd0, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_DELETE, 9'd256, 32'd0,
          '{bole_pkg::ST_BADPOS, 8'd0, 32'd0, 9'd3, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_INS_AT, 9'd3, 32'd7,
          '{bole_pkg::ST_OK, 8'd0, 32'd0, 9'd4, 1'b0, 1'b0}},
        // shifted contents go to the predictor
        '{1'b0, bole_pkg::ACT_DELETE, 9'd1, 32'd0, '0},
        '{1'b0, bole_pkg::ACT_SEARCH, 9'd0, 32'd7, '0},
        '{1'b0, bole_pkg::ACT_READ, 9'd2, 32'd0, '0},
        '{1'b1, bole_pkg::ACT_CLEAR, 9'd0, 32'd0,
          '{bole_pkg::ST_OK, 8'd0, 32'd0, 9'd0, 1'b0, 1'b1}},
        '{1'b1, bole_pkg::ACT_CLEAR, 9'd0, 32'd0,
          '{bole_pkg::ST_OK, 8'd0, 32'd0, 9'd0, 1'b0, 1'b1}},
        '{1'b1, bole_pkg::ACT_INS_AT, 9'd0, 32'h5A5A_A5A5,
          '{bole_pkg::ST_OK, 8'd0, 32'd0, 9'd1, 1'b0, 1'b0}},
        '{1'b1, bole_pkg::ACT_INS_AT, 9'd511, 32'd1,
          '{bole_pkg::ST_BADPOS, 8'd0, 32'd0, 9'd1, 1'b0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic [bole_pkg::ACTION_W-1:0]         action = bole_pkg::ACT_INS_FIRST;
    logic [bole_pkg::POS_W-1:0]            position = '0;
    logic signed [bole_pkg::VALUE_W-1:0]   item_value = '0;

    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic [bole_pkg::STATUS_W-1:0]         status;
    logic [bole_pkg::FOUND_W-1:0]          found_index;
    logic signed [bole_pkg::VALUE_W-1:0]   read_value;
    logic [bole_pkg::COUNT_W-1:0]          entry_count;
    logic                                  is_full;
    logic                                  is_empty;

    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [bole_pkg::CAP_W-1:0]            cfg_data = '0;

    // list mirror kept by the predictor
    logic [bole_pkg::VALUE_W-1:0] mirror_entries [LIST_DEPTH];
    int                           mirror_count = 0;
    int                           mirror_cap = int'(bole_pkg::CAP_RESET);

    list_result_t awaited_results [$];
    list_result_t req_want;
    bit           req_typed;
    bit           req_taken;
    bit           cfg_taken;
    int           burst_left = 0;
    bit           stall_phase = 1'b0;
    int           hold_left = 0;
    int           mismatch_count = 0;
    int           quiet_cycles = 0;

    always #5 clk = ~clk;

    bounded_ordered_list_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .position    (position),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_index (found_index),
        .read_value  (read_value),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // End the run when no channel has moved anything for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Count limit clamped to the list depth; zero means always full.
    function automatic bit at_capacity();
        int lim;
        lim = (mirror_cap > LIST_DEPTH) ? LIST_DEPTH : mirror_cap;
        return mirror_count >= lim;
    endfunction

    // Apply one request to the mirror and return the result the engine owes for it.
    function automatic list_result_t predict_list_op(
        input logic [bole_pkg::ACTION_W-1:0] act,
        input logic [bole_pkg::POS_W-1:0] pos,
        input logic [bole_pkg::VALUE_W-1:0] val);
        list_result_t r;
        int           at;
        bit           hit;
        r = '0;
        r.status = bole_pkg::ST_OK;
        at = int'(pos);
        hit = 1'b0;
        case (act)
            bole_pkg::ACT_INS_FIRST, bole_pkg::ACT_INS_LAST, bole_pkg::ACT_INS_AT:
            begin
                // full wins over a bad position
                if (at_capacity())
                    r.status = bole_pkg::ST_FULL;
                else
                begin
                    if (act == bole_pkg::ACT_INS_FIRST)
                        at = 0;
                    else if (act == bole_pkg::ACT_INS_LAST)
                        at = mirror_count;
                    if (at > mirror_count)
                        r.status = bole_pkg::ST_BADPOS;
                    else
                    begin
                        for (int i = mirror_count; i > at; i--)
                            mirror_entries[i] = mirror_entries[i-1];
                        mirror_entries[at] = val;
                        mirror_count++;
                    end
                end
            end
            bole_pkg::ACT_DELETE:
            begin
                if (mirror_count == 0)
                    r.status = bole_pkg::ST_EMPTY;
                else if (at >= mirror_count)
                    r.status = bole_pkg::ST_BADPOS;
                else
                begin
                    for (int i = at; i + 1 < mirror_count; i++)
                        mirror_entries[i] = mirror_entries[i+1];
                    mirror_entries[mirror_count-1] = '0;
                    mirror_count--;
                end
            end
            bole_pkg::ACT_SEARCH:
            begin
                if (mirror_count == 0)
                    r.status = bole_pkg::ST_EMPTY;
                else
                begin
                    r.status = bole_pkg::ST_NOTFOUND;
                    for (int i = 0; i < mirror_count; i++)
                        if (!hit && mirror_entries[i] == val)
                        begin
                            hit = 1'b1;
                            r.status = bole_pkg::ST_OK;
                            r.found = i[bole_pkg::FOUND_W-1:0];
                        end
                end
            end
            bole_pkg::ACT_UPDATE:
            begin
                if (mirror_count == 0)
                    r.status = bole_pkg::ST_EMPTY;
                else if (at >= mirror_count)
                    r.status = bole_pkg::ST_BADPOS;
                else
                    mirror_entries[at] = val;
            end
            bole_pkg::ACT_READ:
            begin
                if (mirror_count == 0)
                begin
                    r.status = bole_pkg::ST_EMPTY;
                    r.value = bole_pkg::MIN_WORD;
                end
                else if (at >= mirror_count)
                begin
                    r.status = bole_pkg::ST_BADPOS;
                    r.value = bole_pkg::MIN_WORD;
                end
                else
                    r.value = mirror_entries[at];
            end
            default:
                mirror_count = 0;
        endcase
        r.count = mirror_count[bole_pkg::COUNT_W-1:0];
        r.full = at_capacity();
        r.empty = (mirror_count == 0);
        return r;
    endfunction

    // Advance one clock. Check a taken result, record a taken request, and
    // step the receiver's stall pattern. All sampled values are pre-edge.
    task automatic tick();
        list_result_t got;
        list_result_t want;
        @(posedge clk);
        if (out_valid && !out_stall)
        begin
            got.status = status;
            got.found = found_index;
            got.value = read_value;
            got.count = entry_count;
            got.full = is_full;
            got.empty = is_empty;
            if (awaited_results.size() == 0)
                report_mismatch("result with no request waiting", {29'd0, got.status}, 32'd0);
            else
            begin
                want = awaited_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", {29'd0, got.status}, {29'd0, want.status});
                if (got.found !== want.found)
                    report_mismatch("found_index", {24'd0, got.found}, {24'd0, want.found});
                if (got.value !== want.value)
                    report_mismatch("read_value", got.value, want.value);
                if (got.count !== want.count)
                    report_mismatch("entry_count", {23'd0, got.count}, {23'd0, want.count});
                if (got.full !== want.full)
                    report_mismatch("is_full", {31'd0, got.full}, {31'd0, want.full});
                if (got.empty !== want.empty)
                    report_mismatch("is_empty", {31'd0, got.empty}, {31'd0, want.empty});
            end
        end
        if (in_valid && !in_stall)
        begin
            // always run the predictor so the mirror tracks typed rows too
            want = predict_list_op(action, position, item_value);
            awaited_results.push_back(req_typed ? req_want : want);
            req_taken = 1'b1;
        end
        if (cfg_valid && cfg_ready)
            cfg_taken = 1'b1;
        // alternate stall runs and free runs; some free runs are long
        if (hold_left == 0)
        begin
            stall_phase = !stall_phase;
            if (stall_phase)
                hold_left = $urandom_range(1, 6);
            else if ($urandom_range(0, 7) == 0)
                hold_left = $urandom_range(30, 80);
            else
                hold_left = $urandom_range(1, 8);
        end
        hold_left--;
        out_stall <= stall_phase;
    endtask

    // Present one request and hold it until the engine takes it.
    task automatic issue(input logic [bole_pkg::ACTION_W-1:0] act,
                         input logic [bole_pkg::POS_W-1:0] pos,
                         input logic [bole_pkg::VALUE_W-1:0] val, input bit typed,
                         input list_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) tick();
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= act;
        position <= pos;
        item_value <= val;
        req_typed = typed;
        req_want = want;
        req_taken = 1'b0;
        while (!req_taken)
            tick();
    endtask

    // Write the capacity only once the engine has drained and settled.
    task automatic write_capacity(input logic [bole_pkg::CAP_W-1:0] cap);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            tick();
        repeat (SETTLE_CYCLES) tick();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        cfg_taken = 1'b0;
        while (!cfg_taken)
            tick();
        cfg_valid <= 1'b0;
        mirror_cap = int'(cap);
        burst_left = 0;
    endtask

    // Random requests, mostly well formed: positions near the live range and
    // search keys drawn from the list so that hits are common.
    task automatic random_phase(input int n_items, input op_mix_t mix);
        logic [bole_pkg::ACTION_W-1:0] act;
        logic [bole_pkg::POS_W-1:0]    pos;
        logic [bole_pkg::VALUE_W-1:0]  val;
        int                            r;
        int                            t_ins;
        int                            t_del;
        int                            t_find;
        int                            t_upd;
        t_ins  = (mix == MIX_FILL) ? 80 : 45;
        t_del  = (mix == MIX_FILL) ? 85 : 60;
        t_find = (mix == MIX_FILL) ? 90 : 75;
        t_upd  = (mix == MIX_FILL) ? 95 : 85;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < t_ins)
                case ($urandom_range(0, 2))
                    0: act = bole_pkg::ACT_INS_FIRST;
                    1: act = bole_pkg::ACT_INS_LAST;
                    default: act = bole_pkg::ACT_INS_AT;
                endcase
            else if (r < t_del)
                act = bole_pkg::ACT_DELETE;
            else if (r < t_find)
                act = bole_pkg::ACT_SEARCH;
            else if (r < t_upd)
                act = bole_pkg::ACT_UPDATE;
            else if (r < 98 || mix != MIX_ANY)
                act = bole_pkg::ACT_READ;
            else
                act = bole_pkg::ACT_CLEAR;

            r = $urandom_range(0, 9);
            if (r < 7)
                pos = bole_pkg::POS_W'($urandom_range(0, mirror_count));
            else if (r < 8)
                pos = bole_pkg::POS_W'($urandom_range(0, 511));
            else if (r < 9)
                pos = bole_pkg::POS_W'((mirror_count == 0) ? 0 : mirror_count - 1);
            else
                pos = bole_pkg::POS_W'(mirror_count + 1);

            r = $urandom_range(0, 9);
            if (act == bole_pkg::ACT_SEARCH && mirror_count != 0 && r < 6)
                val = mirror_entries[$urandom_range(0, mirror_count - 1)];
            else if (r < 4)
                val = $urandom_range(0, 15) - 8;    // narrow pool to force duplicates
            else if (r < 5)
                case ($urandom_range(0, 3))
                    0: val = bole_pkg::MIN_WORD;
                    1: val = MAX_WORD;
                    2: val = ALL_ONES;
                    default: val = '0;
                endcase
            else
                val = $urandom;

            issue(act, pos, val, 1'b0, '0);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        tick();

        for (int k = 0; k < DIRECTED_N; k++)
            issue(DIRECTED_ROWS[k].act, DIRECTED_ROWS[k].pos, DIRECTED_ROWS[k].val,
                  DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);

        // single slot: full almost all the time
        write_capacity(9'd1);
        random_phase(120, MIX_ANY);
        // zero capacity: every insert is refused, held entries stay
        write_capacity(9'd0);
        random_phase(60, MIX_KEEP);
        write_capacity(9'd16);
        random_phase(250, MIX_ANY);
        // drop the limit under the live count without clearing
        write_capacity(9'd4);
        random_phase(100, MIX_KEEP);
        // above the depth acts as the depth; fill all 256 cells
        write_capacity(9'd511);
        random_phase(380, MIX_FILL);
        random_phase(70, MIX_KEEP);
        write_capacity(9'd256);
        random_phase(200, MIX_ANY);
        write_capacity(9'd2);
        random_phase(100, MIX_ANY);
        write_capacity(9'd200);
        random_phase(150, MIX_ANY);

        // drain, then give a stray extra result time to show up
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            tick();
        repeat (SETTLE_CYCLES) tick();

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
design/bole_pkg.sv
design/bole_cell.sv
design/bole_tree.sv
design/bounded_ordered_list_engine_core.sv
verif/bounded_ordered_list_engine_core_test.sv
